>>> hw/rtl/lfpt_pkg.sv
// lfpt_pkg: shared types and constants for the lf field presence tracker
// used by lfpt_update and lf_field_presence_tracker; no dependencies
package lfpt_pkg;

  localparam int unsigned ID_W      = 11;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned THR_W     = 4;
  localparam int unsigned EV_W      = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // command bytes
  localparam logic [CMD_W-1:0] CMD_NOP         = 8'h00;
  localparam logic [CMD_W-1:0] CMD_MT_BATT_LOW = 8'h1E;
  localparam logic [CMD_W-1:0] CMD_MT          = 8'h1F;
  localparam logic [CMD_W-1:0] CMD_REPEATED    = 8'hFF;

  // event codes
  localparam logic [EV_W-1:0] EV_ENTERING = 2'd0;
  localparam logic [EV_W-1:0] EV_STAYING  = 2'd1;
  localparam logic [EV_W-1:0] EV_EXITING  = 2'd2;
  localparam logic [EV_W-1:0] EV_BATT_LOW = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_THR  = 1'd1;

  // configuration reset values
  localparam logic [TIMER_W-1:0] EXIT_TIMEOUT_RST = 16'd3;
  localparam logic [THR_W-1:0]   CONFIRM_THR_RST  = 4'd3;

  typedef struct packed {
    logic             data_valid;
    logic [ID_W-1:0]  field_id;
    logic [CMD_W-1:0] field_command;
  } item_t;

  typedef struct packed {
    logic             event_valid;
    logic [EV_W-1:0]  event_type;
    logic             send_now;
    logic [ID_W-1:0]  report_id;
    logic             exciter_type;
    logic             flag_entering;
    logic             flag_staying;
    logic             flag_delayed_cmd;
    logic             cmd_confirmed;
    logic             data_accepted;
  } result_t;

endpackage

>>> hw/rtl/lfpt_update.sv
// lfpt_update: tracker state registers and the combinational tick update
// depends on lfpt_pkg
module lfpt_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  lfpt_pkg::item_t                 item,
  input  logic [lfpt_pkg::TIMER_W-1:0]    exit_timeout,
  input  logic [lfpt_pkg::THR_W-1:0]      confirm_thr,
  output lfpt_pkg::result_t               result
);

  logic [lfpt_pkg::ID_W-1:0]    stored_id_r,  stored_id_nxt;
  logic [lfpt_pkg::CMD_W-1:0]   stored_cmd_r, stored_cmd_nxt;
  logic [lfpt_pkg::TIMER_W-1:0] countdown_r,  countdown_nxt;
  logic                         f_enter_r,    f_enter_nxt;
  logic                         f_stay_r,     f_stay_nxt;
  logic                         f_delay_r,    f_delay_nxt;
  logic [lfpt_pkg::CMD_W-1:0]   pending_r,    pending_nxt;
  logic [lfpt_pkg::THR_W-1:0]   repeat_r,     repeat_nxt;

  logic                         timer_on;
  logic                         expired;
  logic                         same_id;
  logic [lfpt_pkg::EV_W-1:0]    ev_raw;
  logic [lfpt_pkg::ID_W-1:0]    ev_id;
  logic [lfpt_pkg::CMD_W-1:0]   ev_cmd;
  logic [lfpt_pkg::THR_W-1:0]   repeat_step;
  logic                         confirmed;

  // timer expires when an active count reaches zero this tick
  assign timer_on = (countdown_r != '0);
  assign expired  = (countdown_r == lfpt_pkg::TIMER_W'(1));
  assign same_id  = (item.field_id == stored_id_r);

  // count advance for a repeated command
  assign repeat_step = (pending_r == lfpt_pkg::CMD_REPEATED) ?
                       repeat_r + lfpt_pkg::THR_W'(1) : '0;

  // next state and result
  always_comb begin
    stored_id_nxt  = stored_id_r;
    stored_cmd_nxt = stored_cmd_r;
    countdown_nxt  = timer_on ? countdown_r - lfpt_pkg::TIMER_W'(1) : countdown_r;
    f_enter_nxt    = f_enter_r;
    f_stay_nxt     = f_stay_r;
    f_delay_nxt    = f_delay_r;
    pending_nxt    = pending_r;
    repeat_nxt     = repeat_r;
    confirmed      = 1'b0;
    ev_raw         = lfpt_pkg::EV_EXITING;
    ev_id          = stored_id_r;
    ev_cmd         = stored_cmd_r;
    result         = '0;

    if (expired) begin
      f_enter_nxt        = 1'b0;
      f_stay_nxt         = 1'b0;
      stored_cmd_nxt     = '0;
      stored_id_nxt      = '0;
      result.event_valid = 1'b1;
    end else if (item.data_valid) begin
      result.event_valid   = 1'b1;
      result.data_accepted = 1'b1;
      stored_id_nxt        = item.field_id;
      stored_cmd_nxt       = item.field_command;
      ev_id                = item.field_id;
      ev_cmd               = item.field_command;
      countdown_nxt        = exit_timeout;
      if (same_id) begin
        ev_raw      = lfpt_pkg::EV_STAYING;
        f_enter_nxt = 1'b0;
        f_stay_nxt  = 1'b1;
      end else begin
        ev_raw      = lfpt_pkg::EV_ENTERING;
        f_enter_nxt = 1'b1;
      end

      // confirmation of repeated commands
      case (item.field_command)
        lfpt_pkg::CMD_NOP, lfpt_pkg::CMD_MT, lfpt_pkg::CMD_MT_BATT_LOW: begin
          f_delay_nxt = 1'b0;
          pending_nxt = '0;
          repeat_nxt  = '0;
        end
        lfpt_pkg::CMD_REPEATED: begin
          if (repeat_step == confirm_thr) begin
            f_delay_nxt = 1'b0;
            pending_nxt = '0;
            repeat_nxt  = '0;
            confirmed   = 1'b1;
          end else begin
            f_delay_nxt = 1'b1;
            pending_nxt = lfpt_pkg::CMD_REPEATED;
            repeat_nxt  = repeat_step;
          end
        end
        default: begin
        end
      endcase
    end

    // event fields, zero when no event
    if (result.event_valid) begin
      result.event_type   = (ev_cmd == lfpt_pkg::CMD_MT_BATT_LOW) ?
                            lfpt_pkg::EV_BATT_LOW : ev_raw;
      result.send_now     = (ev_raw != lfpt_pkg::EV_STAYING);
      result.report_id    = ev_id;
      result.exciter_type = (ev_cmd == lfpt_pkg::CMD_MT_BATT_LOW) ||
                            (ev_cmd == lfpt_pkg::CMD_MT);
    end
    result.flag_entering    = f_enter_nxt;
    result.flag_staying     = f_stay_nxt;
    result.flag_delayed_cmd = f_delay_nxt;
    result.cmd_confirmed    = confirmed;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_id_r  <= '0;
      stored_cmd_r <= '0;
      countdown_r  <= '0;
      f_enter_r    <= 1'b0;
      f_stay_r     <= 1'b0;
      f_delay_r    <= 1'b0;
      pending_r    <= '0;
      repeat_r     <= '0;
    end else if (step_en) begin
      stored_id_r  <= stored_id_nxt;
      stored_cmd_r <= stored_cmd_nxt;
      countdown_r  <= countdown_nxt;
      f_enter_r    <= f_enter_nxt;
      f_stay_r     <= f_stay_nxt;
      f_delay_r    <= f_delay_nxt;
      pending_r    <= pending_nxt;
      repeat_r     <= repeat_nxt;
    end
  end

endmodule

>>> hw/rtl/lf_field_presence_tracker.sv
// lf_field_presence_tracker: top level with input register, result register and config
// depends on lfpt_pkg and lfpt_update
//
// One transaction in gives exactly one result transaction out. A transaction is
// taken into an input register, the tracker state is updated from it and the
// result lands in an output register. A new transaction is accepted every cycle
// while the output side keeps taking results. The rate is set by the state
// update in lfpt_update. The configuration port is always ready; write it only
// while the block is idle.
module lf_field_presence_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_data_valid,
  input  logic [lfpt_pkg::ID_W-1:0]           in_field_id,
  input  logic [lfpt_pkg::CMD_W-1:0]          in_field_command,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_event_valid,
  output logic [lfpt_pkg::EV_W-1:0]           out_event_type,
  output logic                                out_send_now,
  output logic [lfpt_pkg::ID_W-1:0]           out_report_id,
  output logic                                out_exciter_type,
  output logic                                out_flag_entering,
  output logic                                out_flag_staying,
  output logic                                out_flag_delayed_cmd,
  output logic                                out_cmd_confirmed,
  output logic                                out_data_accepted,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfpt_pkg::TIMER_W-1:0]        cfg_data
);

  logic                          in_vld_r;
  lfpt_pkg::item_t               in_item_r;
  logic                          out_vld_r;
  lfpt_pkg::result_t             out_res_r;
  lfpt_pkg::result_t             step_res;
  logic [lfpt_pkg::TIMER_W-1:0]  exit_timeout_r;
  logic [lfpt_pkg::THR_W-1:0]    confirm_thr_r;
  logic                          step_en;
  logic                          in_fire;

  // handshake: step when the result register is free or being drained
  assign step_en   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || step_en;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.data_valid    <= in_data_valid;
      in_item_r.field_id      <= in_field_id;
      in_item_r.field_command <= in_field_command;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_timeout_r <= lfpt_pkg::EXIT_TIMEOUT_RST;
      confirm_thr_r  <= lfpt_pkg::CONFIRM_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfpt_pkg::CFG_EXIT_TIMEOUT: exit_timeout_r <= cfg_data;
        lfpt_pkg::CFG_CONFIRM_THR:  confirm_thr_r  <= cfg_data[lfpt_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // tracker state and tick update
  lfpt_update u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .item         (in_item_r),
    .exit_timeout (exit_timeout_r),
    .confirm_thr  (confirm_thr_r),
    .result       (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_en) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_event_valid      = out_res_r.event_valid;
  assign out_event_type       = out_res_r.event_type;
  assign out_send_now         = out_res_r.send_now;
  assign out_report_id        = out_res_r.report_id;
  assign out_exciter_type     = out_res_r.exciter_type;
  assign out_flag_entering    = out_res_r.flag_entering;
  assign out_flag_staying     = out_res_r.flag_staying;
  assign out_flag_delayed_cmd = out_res_r.flag_delayed_cmd;
  assign out_cmd_confirmed    = out_res_r.cmd_confirmed;
  assign out_data_accepted    = out_res_r.data_accepted;

endmodule
